// ===== hdl/ctc_pft_pkg.sv =====
`default_nettype none

package ctc_pft_pkg;

   localparam int unsigned MsWidth    = 23;
   localparam int unsigned ClkWidth   = 11;
   localparam int unsigned TopWidth   = 16;
   localparam int unsigned CountWidth = 32;

   localparam int unsigned TopMax     = 65535;
   localparam int unsigned TickNum    = 1024;
   localparam int unsigned UsPerMs    = 1000;
   localparam int unsigned ClkReset   = 16;

   localparam int unsigned DivSteps   = CountWidth;
   localparam int unsigned StepWidth  = $clog2(DivSteps);

   localparam logic KindSetPeriod = 1'b0;
   localparam logic KindEvent     = 1'b1;

   typedef enum logic [4:0] {
      StIdle   = 5'b00001,
      StTick   = 5'b00010,
      StTotal  = 5'b00100,
      StSearch = 5'b01000,
      StFinish = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/ctc_pft_req_if.sv =====
`default_nettype none

interface ctc_pft_req_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [ctc_pft_pkg::MsWidth-1:0]   desired_ms;

   modport source (output valid, output kind, output desired_ms, input ready);
   modport sink   (input valid, input kind, input desired_ms, output ready);
endinterface

`default_nettype wire

// ===== hdl/ctc_pft_rsp_if.sv =====
`default_nettype none

interface ctc_pft_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 fire;
   logic [ctc_pft_pkg::TopWidth-1:0]     compare_top;
   logic [ctc_pft_pkg::CountWidth-1:0]   match_count;

   modport source (output valid, output fire, output compare_top, output match_count,
                   input ready);
   modport sink   (input valid, input fire, input compare_top, input match_count,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/ctc_period_factoring_timer_unit.sv =====
`default_nettype none

// compare-match event: result registered the next cycle; one per cycle while rsp_chan is ready
// set period: 1 to 65535 divisor candidates are tried in a downward search; one shared
//    32-step restoring divider computes the tick, the total and every remainder of that
//    search, and input is not taken meanwhile
// zero clock setting goes straight to the finish state, a zero tick or a zero total skips the later stages
// reset: synchronous, clears the sequencer, counter, match count and top; clock_mhz returns to 16
module ctc_period_factoring_timer_unit #(
   parameter int unsigned TopLimit = ctc_pft_pkg::TopMax
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [ctc_pft_pkg::ClkWidth-1:0]    csr_wr_data,
   ctc_pft_req_if.sink                              req_chan,
   ctc_pft_rsp_if.source                            rsp_chan
);
   import ctc_pft_pkg::*;

   state_type               state_ff, state_in;
   logic [ClkWidth-1:0]     clk_mhz_ff;
   logic [CountWidth-1:0]   evt_ff, evt_in;
   logic [CountWidth-1:0]   target_ff, target_in;
   logic [TopWidth-1:0]     top_ff, top_in;

   // shared divider
   logic [TopWidth-1:0]     rem_ff, rem_in;
   logic [CountWidth-1:0]   quo_ff, quo_in;
   logic [TopWidth-1:0]     dsr_ff, dsr_in;
   logic [StepWidth-1:0]    cnt_ff, cnt_in;
   logic [CountWidth-1:0]   work_ff, work_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_fire_ff, rsp_fire_in;
   logic [TopWidth-1:0]     rsp_top_ff, rsp_top_in;
   logic [CountWidth-1:0]   rsp_match_ff, rsp_match_in;

   logic [TopWidth:0]       shifted;
   logic [TopWidth:0]       diff;
   logic                    ge;
   logic [TopWidth-1:0]     rem_step;
   logic [CountWidth-1:0]   quo_step;
   logic                    last_step;
   logic                    out_free;
   logic                    req_take;
   logic [CountWidth-1:0]   prod_full;
   logic [CountWidth-1:0]   evt_inc;
   logic                    evt_fire;

   assign shifted   = {rem_ff, quo_ff[CountWidth-1]};
   assign diff      = shifted - {1'b0, dsr_ff};
   assign ge        = (shifted >= {1'b0, dsr_ff});
   assign rem_step  = ge ? diff[TopWidth-1:0] : shifted[TopWidth-1:0];
   assign quo_step  = {quo_ff[CountWidth-2:0], ge};
   assign last_step = (cnt_ff == StepWidth'(DivSteps - 1));

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == StIdle) && out_free;
   assign req_take  = req_chan.valid && req_chan.ready;

   assign prod_full = CountWidth'(req_chan.desired_ms) * CountWidth'(UsPerMs);
   assign evt_inc   = evt_ff + CountWidth'(1);
   assign evt_fire  = (target_ff != '0) && (evt_inc == target_ff);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.fire        = rsp_fire_ff;
   assign rsp_chan.compare_top = rsp_top_ff;
   assign rsp_chan.match_count = rsp_match_ff;

   always_comb begin
      state_in     = state_ff;
      evt_in       = evt_ff;
      target_in    = target_ff;
      top_in       = top_ff;
      rem_in       = rem_step;
      quo_in       = quo_step;
      dsr_in       = dsr_ff;
      cnt_in       = cnt_ff + StepWidth'(1);
      work_in      = work_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_fire_in  = rsp_fire_ff;
      rsp_top_in   = rsp_top_ff;
      rsp_match_in = rsp_match_ff;

      case (state_ff)
         StIdle: begin
            if (req_take) begin
               if (req_chan.kind == KindEvent) begin
                  evt_in       = evt_fire ? '0 : evt_inc;
                  rsp_valid_in = 1'b1;
                  rsp_fire_in  = evt_fire;
                  rsp_top_in   = top_ff;
                  rsp_match_in = target_ff;
               end else begin
                  work_in = prod_full;
                  if (clk_mhz_ff == '0) begin
                     top_in    = TopWidth'(TopLimit - 1);
                     target_in = '0;
                     state_in  = StFinish;
                  end else begin
                     rem_in   = '0;
                     quo_in   = CountWidth'(TickNum);
                     dsr_in   = TopWidth'(clk_mhz_ff);
                     cnt_in   = '0;
                     state_in = StTick;
                  end
               end
            end
         end
         StTick: begin
            if (last_step) begin
               if (quo_step == '0) begin
                  top_in    = TopWidth'(TopLimit - 1);
                  target_in = '0;
                  state_in  = StFinish;
               end else begin
                  rem_in   = '0;
                  quo_in   = work_ff;
                  dsr_in   = quo_step[TopWidth-1:0];
                  cnt_in   = '0;
                  state_in = StTotal;
               end
            end
         end
         StTotal: begin
            if (last_step) begin
               if (quo_step == '0) begin
                  top_in    = TopWidth'(TopLimit - 1);
                  target_in = '0;
                  state_in  = StFinish;
               end else begin
                  work_in  = quo_step;
                  rem_in   = '0;
                  quo_in   = quo_step;
                  dsr_in   = (quo_step < CountWidth'(TopLimit)) ? quo_step[TopWidth-1:0]
                                                                : TopWidth'(TopLimit);
                  cnt_in   = '0;
                  state_in = StSearch;
               end
            end
         end
         StSearch: begin
            if (last_step) begin
               if (rem_step == '0) begin
                  top_in    = dsr_ff - TopWidth'(1);
                  target_in = quo_step;
                  state_in  = StFinish;
               end else begin
                  rem_in = '0;
                  quo_in = work_ff;
                  dsr_in = dsr_ff - TopWidth'(1);
                  cnt_in = '0;
               end
            end
         end
         StFinish: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fire_in  = 1'b0;
               rsp_top_in   = top_ff;
               rsp_match_in = target_ff;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         clk_mhz_ff   <= ClkWidth'(ClkReset);
         evt_ff       <= '0;
         target_ff    <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            clk_mhz_ff <= csr_wr_data;
         end
         evt_ff       <= evt_in;
         target_ff    <= target_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dsr_ff       <= dsr_in;
      cnt_ff       <= cnt_in;
      work_ff      <= work_in;
      rsp_fire_ff  <= rsp_fire_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_match_ff <= rsp_match_in;
   end

endmodule

`default_nettype wire

// ===== sim/ctc_period_factoring_timer_unit_tb.sv =====
`default_nettype none

module ctc_period_factoring_timer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ctc_pft_pkg::*;

   localparam int unsigned ClockPeriod   = 10;
   localparam int unsigned MsMax         = 4294967;
   localparam int unsigned SearchCap     = 128;
   localparam int unsigned ItemsPerPhase = 172;
   localparam int unsigned RandomPhases  = 10;

   typedef struct {
      logic                  kind;
      logic [MsWidth-1:0]    ms;
   } timer_item_type;

   typedef struct {
      logic                  fire;
      logic [TopWidth-1:0]   top;
      logic [CountWidth-1:0] count;
   } timer_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [ClkWidth-1:0]   csr_wr_data = '0;
   logic                  drv_valid   = 1'b0;
   logic                  drv_kind    = 1'b0;
   logic [MsWidth-1:0]    drv_ms      = '0;
   logic                  sink_ready  = 1'b0;

   ctc_pft_req_if req_bus ();
   ctc_pft_rsp_if rsp_bus ();

   assign req_bus.valid      = drv_valid;
   assign req_bus.kind       = drv_kind;
   assign req_bus.desired_ms = drv_ms;
   assign rsp_bus.ready      = sink_ready;

   ctc_period_factoring_timer_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   // shadow copy of the timer
   logic [ClkWidth-1:0]   sh_clock_mhz = ClkWidth'(ClkReset);
   logic [CountWidth-1:0] sh_events    = '0;
   logic [CountWidth-1:0] sh_target    = '0;
   logic [TopWidth-1:0]   sh_top       = '0;
   logic [CountWidth-1:0] planned_count = '0;

   timer_item_type   item_fifo[$];
   timer_result_type due_results[$];

   int unsigned     queued_total   = 0;
   int unsigned     accepted_total = 0;
   int unsigned     loads_seen     = 0;
   int unsigned     events_seen    = 0;
   int unsigned     fires_seen     = 0;
   int unsigned     settings_seen  = 0;
   int unsigned     errors         = 0;
   int unsigned     req_gap        = 0;
   int unsigned     rsp_stall      = 0;
   longint unsigned cycles         = 0;
   longint unsigned cycle_budget   = 0;
   bit              calm           = 1'b0;
   bit              req_handshake  = 1'b0;

   always #(ClockPeriod / 2) clock = ~clock;

   // tick period, total ticks and downward divisor search; returns candidates tried
   function automatic int unsigned factor_period(input logic [ClkWidth-1:0] clk_mhz,
                                                 input logic [MsWidth-1:0] ms,
                                                 input int unsigned cap,
                                                 output logic [TopWidth-1:0] top,
                                                 output logic [CountWidth-1:0] count);
      logic [31:0] tick;
      logic [31:0] prod;
      logic [31:0] total;
      logic [31:0] divisor;
      tick = (clk_mhz == '0 || clk_mhz > TickNum) ? 32'd0 : TickNum / clk_mhz;
      prod = 32'(ms) * 32'(UsPerMs);
      total = (tick == 32'd0) ? 32'd0 : prod / tick;
      divisor = TopMax;
      while (divisor > 1 && (total % divisor) != 0 && (TopMax + 1 - divisor) <= cap)
         divisor = divisor - 1;
      top = TopWidth'(divisor - 1);
      count = total / divisor;
      return TopMax + 1 - divisor;
   endfunction

   // a period whose divisor search stays short under the current clock
   function automatic logic [MsWidth-1:0] pick_period_ms(input int unsigned max_mult);
      logic [TopWidth-1:0]   t_top;
      logic [CountWidth-1:0] t_cnt;
      longint unsigned       tick;
      longint unsigned       d;
      longint unsigned       j;
      longint unsigned       cand;
      tick = (sh_clock_mhz == '0 || sh_clock_mhz > TickNum) ? 0 : TickNum / sh_clock_mhz;
      if (tick == 0)
         return MsWidth'($urandom_range(0, MsMax));
      for (int attempt = 0; attempt < 64; attempt++) begin
         d = TopMax - $urandom_range(0, SearchCap - 1);
         j = $urandom_range(1, max_mult);
         for (int way = 0; way < 3; way++) begin
            case (way)
               0: begin
                  cand = (d * j * tick + UsPerMs - 1) / UsPerMs;
               end
               1: begin
                  cand = tick * d * longint'($urandom_range(1, 65));
               end
               default: begin
                  cand = $urandom_range(0, MsMax);
               end
            endcase
            if (cand <= MsMax) begin
               if (factor_period(sh_clock_mhz, MsWidth'(cand), SearchCap, t_top, t_cnt)
                   <= SearchCap)
                  return MsWidth'(cand);
            end
         end
      end
      return '0;
   endfunction

   function automatic logic [ClkWidth-1:0] pick_clock();
      case ($urandom_range(0, 9))
         0: return ClkWidth'($urandom_range(TickNum + 1, 2047));
         1: return ClkWidth'(1);
         2: return ClkWidth'(TickNum);
         3: return ClkWidth'(ClkReset);
         4, 5: return ClkWidth'($urandom_range(1, 64));
         default: return ClkWidth'($urandom_range(1, TickNum));
      endcase
   endfunction

   task automatic advance_timer(input timer_item_type it);
      timer_result_type      res;
      logic [TopWidth-1:0]   new_top;
      logic [CountWidth-1:0] new_count;
      res.fire = 1'b0;
      if (it.kind == KindSetPeriod) begin
         void'(factor_period(sh_clock_mhz, it.ms, TopMax, new_top, new_count));
         sh_top = new_top;
         sh_target = new_count;
         loads_seen++;
      end else begin
         sh_events = sh_events + 1;
         if (sh_target != '0 && sh_events == sh_target) begin
            res.fire = 1'b1;
            sh_events = '0;
         end
         events_seen++;
      end
      res.top = sh_top;
      res.count = sh_target;
      due_results.push_back(res);
   endtask

   task automatic queue_item(input logic kind, input logic [MsWidth-1:0] ms);
      timer_item_type      it;
      logic [TopWidth-1:0] t_top;
      int unsigned         tries;
      it.kind = kind;
      it.ms = ms;
      tries = 0;
      if (kind == KindSetPeriod)
         tries = factor_period(sh_clock_mhz, ms, TopMax, t_top, planned_count);
      cycle_budget += 24 + ((kind == KindSetPeriod) ? 2 + 32 * (2 + tries) : 0);
      item_fifo.push_back(it);
      queued_total++;
   endtask

   task automatic queue_events(input int unsigned n);
      for (int i = 0; i < n; i++)
         queue_item(KindEvent, MsWidth'($urandom));
   endtask

   // load a period, then compare events: enough to reach a match count of 40 or less, else 1 to 24
   task automatic queue_run(input int unsigned max_mult);
      queue_item(KindSetPeriod, pick_period_ms(max_mult));
      if (planned_count != '0 && planned_count <= 40)
         queue_events(planned_count + $urandom_range(0, 3));
      else
         queue_events($urandom_range(1, 24));
   endtask

   task automatic wait_drained();
      while (accepted_total != queued_total || due_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_clock(input logic [ClkWidth-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sh_clock_mhz = value;
      settings_seen++;
   endtask

   // input transfer
   always @(posedge clock) begin : req_accept
      timer_item_type got;
      req_handshake <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         got.kind = req_bus.kind;
         got.ms = req_bus.desired_ms;
         advance_timer(got);
         accepted_total++;
      end
   end

   always @(negedge clock) begin : req_drive
      timer_item_type nxt;
      if (!drv_valid || req_handshake) begin
         if (req_gap != 0) begin
            req_gap <= req_gap - 1;
            drv_valid <= 1'b0;
         end else if (item_fifo.size() != 0) begin
            nxt = item_fifo.pop_front();
            drv_valid <= 1'b1;
            drv_kind <= nxt.kind;
            drv_ms <= nxt.ms;
            if (!calm && $urandom_range(0, 5) == 0)
               req_gap <= $urandom_range(1, 9);
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_pace
      if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
         sink_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         rsp_stall <= $urandom_range(0, 8);
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= 1'b1;
      end
   end

   // result transfer
   always @(posedge clock) begin : rsp_check
      timer_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_results.size() == 0) begin
            $display("%0t unexpected result: fire %0d top %0d count %0d", $time,
                     rsp_bus.fire, rsp_bus.compare_top, rsp_bus.match_count);
            errors++;
         end else begin
            want = due_results.pop_front();
            if (rsp_bus.fire !== want.fire) begin
               $display("%0t fire: expected %0d actual %0d", $time, want.fire, rsp_bus.fire);
               errors++;
            end
            if (rsp_bus.compare_top !== want.top) begin
               $display("%0t compare_top: expected %0d actual %0d", $time, want.top,
                        rsp_bus.compare_top);
               errors++;
            end
            if (rsp_bus.match_count !== want.count) begin
               $display("%0t match_count: expected %0d actual %0d", $time, want.count,
                        rsp_bus.match_count);
               errors++;
            end
            if (want.fire)
               fires_seen++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > 20000 + 4 * cycle_budget) begin
         $display("%0t timeout after %0d cycles", $time, cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned r;
      int unsigned phase_end;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset clock setting: zero totals, fires, counter left above a new match count
      queue_item(KindEvent, '1);
      queue_item(KindSetPeriod, '0);
      queue_events(2);
      queue_run(3);
      queue_item(KindSetPeriod, pick_period_ms(6));
      queue_events(2);
      queue_item(KindSetPeriod, pick_period_ms(1));
      queue_events(2);
      wait_drained();

      // slowest tick: largest period and a period whose product wraps
      write_clock(ClkWidth'(1));
      queue_item(KindSetPeriod, MsWidth'(MsMax));
      queue_item(KindEvent, '0);
      queue_item(KindSetPeriod, '1);
      queue_item(KindEvent, '1);
      wait_drained();

      write_clock(ClkWidth'(TickNum));
      queue_run(2);
      wait_drained();

      // zero tick period
      write_clock('0);
      queue_item(KindSetPeriod, MsWidth'(4242));
      queue_item(KindEvent, '0);
      wait_drained();

      write_clock('1);
      queue_item(KindSetPeriod, MsWidth'($urandom_range(0, MsMax)));
      queue_item(KindEvent, '0);

      for (int p = 0; p < RandomPhases; p++) begin
         wait_drained();
         if (p == RandomPhases - 1)
            calm = 1'b1;
         write_clock((p == RandomPhases - 1) ? ClkWidth'($urandom_range(64, TickNum))
                                             : pick_clock());
         phase_end = queued_total + ItemsPerPhase;
         while (queued_total < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               queue_run(12);
            end else if (r < 75) begin
               queue_item(KindSetPeriod, '0);
               queue_events($urandom_range(1, 6));
            end else begin
               queue_events($urandom_range(1, 8));
            end
         end
      end

      wait_drained();
      repeat (40) @(negedge clock);
      $display("covered %0d period loads and %0d compare events over %0d clock settings",
               loads_seen, events_seen, settings_seen);
      $display("%0d fire results checked, %0d mismatches", fires_seen, errors);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
